/* sv/channel_binding_table_core_macros.svh */
// Assertion macros used by the checker file of the channel binding table.
`ifndef CHANNEL_BINDING_TABLE_CORE_MACROS_SVH
`define CHANNEL_BINDING_TABLE_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CBT_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("channel binding table check failed");

// Check a property on every clock edge, reset included.
`define CBT_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("channel binding table reset check failed");

`endif

/* sv/cbt_pkg.sv */
// Shared constants, codes and controller interface types of the channel binding table.
package cbt_pkg;

    localparam int SLOT_COUNT   = 16;
    localparam int CHANNEL_BITS = 8;
    localparam int PAYLOAD_BITS = 32;

    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);
    localparam int CH_COUNT   = 1 << CHANNEL_BITS;
    // Lowest free channel can never exceed the number of slots
    localparam int FREE_W     = (SLOT_COUNT + 1 < CH_COUNT) ? SLOT_COUNT + 1 : CH_COUNT;
    localparam int FREE_IDX_W = $clog2(FREE_W);
    localparam int LIST_MAX   = (SLOT_COUNT < 16) ? SLOT_COUNT : 16;
    localparam int LIST_W     = $clog2(LIST_MAX + 1);
    localparam int KEY_W      = CHANNEL_BITS + IDX_W;

    // Field widths of the request and result items
    localparam int OP_W     = 3;
    localparam int HOST_W   = 64;
    localparam int PORT_W   = 16;
    localparam int CH_W     = 9;
    localparam int PAY_W    = 32;
    localparam int LIMIT_W  = 5;
    localparam int STATUS_W = 3;
    localparam int ACT_W    = 5;
    localparam int TDATA_W  = 136;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_UPSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_GET    = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd4;
    localparam logic [OP_W-1:0] OP_LIST   = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT,
        ST_LSCAN,
        ST_LOUT
    } cbt_state_t;

    typedef struct packed {
        logic             load_req;
        logic             scan_step;
        logic             decide;
        logic             lscan_step;
        logic             list_out;
        logic [IDX_W-1:0] idx;
    } cbt_cmd_t;

    typedef struct packed {
        logic list_more;
    } cbt_sts_t;

endpackage

/* sv/channel_binding_table_core.sv */
// Top level of the channel binding table: controller and datapath.
// Binds host key and port to channel numbers in a table of SLOT_COUNT slots and
// takes one request at a time. Every request first reads all slots through one
// read port, one slot per cycle, then passes the decide state, so a request with
// a single result is offered after the slot pass and decision, and waits until
// it is taken. A list request with n entries then makes one more full slot pass
// and one output state for each entry that it returns, and each result also
// waits in the emit state until it is taken.
// No new request is taken until the last result of the current one has been
// taken; the block then returns to idle, where it accepts the next request.
// No clearing pass is needed after reset.
module channel_binding_table_core
    import cbt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // op[2:0], host_key[66:3], port[82:67], channel[91:83], payload[123:92],
    // limit[128:124]
    input  logic [TDATA_W-1:0] s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // status[2:0], channel_out[11:3], host_out[75:12], port_out[91:76],
    // payload_out[123:92], active_count[128:124]
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    cbt_cmd_t cmd;
    cbt_sts_t sts;

    cbt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cbt_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

/* sv/cbt_ctrl.sv */
// Controller state machine: sequences slot scans, decision and result handshakes.
module cbt_ctrl
    import cbt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  cbt_sts_t sts,
    output cbt_cmd_t cmd
);

    cbt_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             idx_last;

    assign idx_last = (idx_reg == IDX_W'(SLOT_COUNT - 1));

    // Next state and scan index
    always_comb begin
        state_next = state_reg;
        idx_next   = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                idx_next = idx_last ? '0 : idx_reg + 1'b1;
                if (idx_last) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = sts.list_more ? ST_LSCAN : ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) state_next = sts.list_more ? ST_LSCAN : ST_IDLE;
            end
            ST_LSCAN: begin
                idx_next = idx_last ? '0 : idx_reg + 1'b1;
                if (idx_last) state_next = ST_LOUT;
            end
            ST_LOUT: begin
                state_next = ST_EMIT;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive handshakes and datapath commands
    always_comb begin
        s_tready       = (state_reg == ST_IDLE);
        m_tvalid       = (state_reg == ST_EMIT);
        cmd.load_req   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.scan_step  = (state_reg == ST_SCAN);
        cmd.decide     = (state_reg == ST_DECIDE);
        cmd.lscan_step = (state_reg == ST_LSCAN);
        cmd.list_out   = (state_reg == ST_LOUT);
        cmd.idx        = idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* sv/cbt_dp.sv */
// Datapath: slot registers, scan accumulators, decision logic and result register.
module cbt_dp
    import cbt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cbt_cmd_t           cmd,
    output cbt_sts_t           sts,
    input  logic [TDATA_W-1:0] s_tdata,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    // Slot store
    logic                    valid_reg [SLOT_COUNT];
    logic [HOST_W-1:0]       host_reg  [SLOT_COUNT];
    logic [PORT_W-1:0]       port_reg  [SLOT_COUNT];
    logic [CHANNEL_BITS-1:0] chan_reg  [SLOT_COUNT];
    logic [PAYLOAD_BITS-1:0] pay_reg   [SLOT_COUNT];
    logic [COUNT_W-1:0]      used_reg;

    // Latched request
    logic [OP_W-1:0]    req_op_reg;
    logic [HOST_W-1:0]  req_host_reg;
    logic [PORT_W-1:0]  req_port_reg;
    logic [CH_W-1:0]    req_ch_reg;
    logic [PAY_W-1:0]   req_pay_reg;
    logic [LIMIT_W-1:0] req_limit_reg;

    // Scan accumulators
    logic                    ch_found_reg, host_found_reg, free_found_reg;
    logic [IDX_W-1:0]        ch_slot_reg, free_slot_reg;
    logic [CHANNEL_BITS-1:0] host_ch_reg;
    logic [FREE_W-1:0]       used_map_reg;
    logic [SLOT_COUNT-1:0]   mask_reg;
    logic [LIST_W-1:0]       sel_cnt_reg, emit_cnt_reg;

    // List ordering state
    logic             prev_valid_reg, best_valid_reg;
    logic [KEY_W-1:0] prev_key_reg, best_key_reg;
    logic [IDX_W-1:0] best_slot_reg;

    // Result register
    logic [STATUS_W-1:0] res_status_reg;
    logic [CH_W-1:0]     res_ch_reg;
    logic [HOST_W-1:0]   res_host_reg;
    logic [PORT_W-1:0]   res_port_reg;
    logic [PAY_W-1:0]    res_pay_reg;
    logic [ACT_W-1:0]    res_act_reg;
    logic                res_last_reg;

    logic [IDX_W-1:0]        rd_idx;
    logic                    rd_valid;
    logic [HOST_W-1:0]       rd_host;
    logic [PORT_W-1:0]       rd_port;
    logic [CHANNEL_BITS-1:0] rd_chan;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic                    ch_ok, hit_ch, hit_host;
    logic [FREE_W-1:0]       map_set;
    logic [LIST_W-1:0]       cap;
    logic                    low_found;
    logic [FREE_IDX_W-1:0]   low_free;
    logic [KEY_W-1:0]        key_cur;
    logic                    take;

    logic [STATUS_W-1:0]     d_status;
    logic [CH_W-1:0]         d_ch;
    logic                    d_data, wr_en, clr_en, inc, dec;
    logic [IDX_W-1:0]        wr_idx;
    logic [CHANNEL_BITS-1:0] wr_chan;
    logic [COUNT_W-1:0]      used_next;

    // Select the one slot read this cycle
    always_comb begin
        if (cmd.list_out) rd_idx = best_slot_reg;
        else if (cmd.decide) rd_idx = ch_slot_reg;
        else rd_idx = cmd.idx;
        rd_valid = valid_reg[rd_idx];
        rd_host  = host_reg[rd_idx];
        rd_port  = port_reg[rd_idx];
        rd_chan  = chan_reg[rd_idx];
        rd_pay   = pay_reg[rd_idx];
    end

    // Compare the scanned slot against the request
    always_comb begin
        ch_ok    = !req_ch_reg[CH_W-1] && (32'(req_ch_reg[CH_W-2:0]) < CH_COUNT);
        hit_ch   = rd_valid && ch_ok && (32'(rd_chan) == 32'(req_ch_reg[CH_W-2:0]));
        hit_host = rd_valid && (rd_host == req_host_reg) && (rd_port == req_port_reg);
        map_set  = '0;
        for (int j = 0; j < FREE_W; j++) begin
            if (rd_valid && (32'(rd_chan) == j)) map_set[j] = 1'b1;
        end
        if (32'(req_limit_reg) > LIST_MAX) cap = LIST_W'(LIST_MAX);
        else cap = LIST_W'(req_limit_reg);
    end

    // Find the lowest channel not in use
    always_comb begin
        low_found = 1'b0;
        low_free  = '0;
        for (int j = FREE_W - 1; j >= 0; j--) begin
            if (!used_map_reg[j]) begin
                low_found = 1'b1;
                low_free  = FREE_IDX_W'(j);
            end
        end
    end

    // Pick the next list entry: smallest key above the one emitted last
    always_comb begin
        key_cur = {rd_chan, cmd.idx};
        take    = mask_reg[cmd.idx]
                  && (!prev_valid_reg || (key_cur > prev_key_reg))
                  && (!best_valid_reg || (cmd.idx == '0) || (key_cur < best_key_reg));
    end

    // Decide the outcome of a single-result operation
    always_comb begin
        d_status = STATUS_OK;
        d_ch     = '1;
        d_data   = 1'b0;
        wr_en    = 1'b0;
        clr_en   = 1'b0;
        inc      = 1'b0;
        dec      = 1'b0;
        wr_idx   = free_slot_reg;
        wr_chan  = CHANNEL_BITS'(req_ch_reg[CH_W-2:0]);
        case (req_op_reg)
            OP_ADD: begin
                if (req_host_reg == '0) begin
                    d_status = STATUS_BAD;
                end else if (host_found_reg) begin
                    d_ch = CH_W'(host_ch_reg);
                end else if (!free_found_reg) begin
                    d_status = STATUS_FULL;
                end else if (ch_ok && !ch_found_reg) begin
                    wr_en = 1'b1;
                    inc   = 1'b1;
                    d_ch  = req_ch_reg;
                end else if (low_found) begin
                    wr_en   = 1'b1;
                    inc     = 1'b1;
                    wr_chan = CHANNEL_BITS'(low_free);
                    d_ch    = CH_W'(low_free);
                end else begin
                    d_status = STATUS_FULL;
                end
            end
            OP_UPSERT: begin
                if ((req_host_reg == '0) || !ch_ok) begin
                    d_status = STATUS_BAD;
                end else if (ch_found_reg) begin
                    wr_en  = 1'b1;
                    wr_idx = ch_slot_reg;
                    d_ch   = req_ch_reg;
                end else if (free_found_reg) begin
                    wr_en = 1'b1;
                    inc   = 1'b1;
                    d_ch  = req_ch_reg;
                end else begin
                    d_status = STATUS_FULL;
                end
            end
            OP_REMOVE: begin
                if (ch_found_reg) begin
                    clr_en = 1'b1;
                    dec    = (used_reg != '0);
                    d_ch   = req_ch_reg;
                end else begin
                    d_status = STATUS_NFOUND;
                end
            end
            OP_GET: begin
                if (ch_found_reg) begin
                    d_ch   = CH_W'(rd_chan);
                    d_data = 1'b1;
                end else begin
                    d_status = STATUS_NFOUND;
                end
            end
            OP_FIND: begin
                if (host_found_reg) d_ch = CH_W'(host_ch_reg);
                else d_status = STATUS_NFOUND;
            end
            OP_LIST: begin
                d_status = STATUS_EMPTY;
            end
            default: begin
                d_status = STATUS_BAD;
            end
        endcase
        used_next = used_reg;
        if (inc) used_next = used_reg + 1'b1;
        if (dec) used_next = used_reg - 1'b1;
    end

    // Slot store updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) valid_reg[i] <= 1'b0;
            used_reg <= '0;
        end else if (cmd.decide) begin
            if (wr_en) valid_reg[wr_idx] <= 1'b1;
            if (clr_en) valid_reg[ch_slot_reg] <= 1'b0;
            used_reg <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide && wr_en) begin
            host_reg[wr_idx] <= req_host_reg;
            port_reg[wr_idx] <= req_port_reg;
            chan_reg[wr_idx] <= wr_chan;
            pay_reg[wr_idx]  <= PAYLOAD_BITS'(req_pay_reg);
        end
    end

    // Latch the request, clear the scan state, and update it during scans and list output
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_op_reg     <= s_tdata[2:0];
            req_host_reg   <= s_tdata[66:3];
            req_port_reg   <= s_tdata[82:67];
            req_ch_reg     <= s_tdata[91:83];
            req_pay_reg    <= s_tdata[123:92];
            req_limit_reg  <= s_tdata[128:124];
            ch_found_reg   <= 1'b0;
            host_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            used_map_reg   <= '0;
            mask_reg       <= '0;
            sel_cnt_reg    <= '0;
            emit_cnt_reg   <= '0;
            prev_valid_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            if (hit_ch && !ch_found_reg) begin
                ch_found_reg <= 1'b1;
                ch_slot_reg  <= cmd.idx;
            end
            if (hit_host && !host_found_reg) begin
                host_found_reg <= 1'b1;
                host_ch_reg    <= rd_chan;
            end
            if (!rd_valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= cmd.idx;
            end
            used_map_reg <= used_map_reg | map_set;
            if (rd_valid && (sel_cnt_reg < cap)) begin
                mask_reg[cmd.idx] <= 1'b1;
                sel_cnt_reg       <= sel_cnt_reg + 1'b1;
            end
        end else if (cmd.lscan_step) begin
            if (cmd.idx == '0) best_valid_reg <= take;
            else if (take) best_valid_reg <= 1'b1;
            if (take) begin
                best_key_reg  <= key_cur;
                best_slot_reg <= cmd.idx;
            end
        end else if (cmd.list_out) begin
            prev_valid_reg <= 1'b1;
            prev_key_reg   <= best_key_reg;
            emit_cnt_reg   <= emit_cnt_reg + 1'b1;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            res_status_reg <= d_status;
            res_ch_reg     <= d_ch;
            res_host_reg   <= d_data ? rd_host : '0;
            res_port_reg   <= d_data ? rd_port : '0;
            res_pay_reg    <= d_data ? PAY_W'(rd_pay) : '0;
            res_act_reg    <= ACT_W'(used_next);
            res_last_reg   <= 1'b1;
        end else if (cmd.list_out) begin
            res_status_reg <= STATUS_OK;
            res_ch_reg     <= CH_W'(rd_chan);
            res_host_reg   <= rd_host;
            res_port_reg   <= rd_port;
            res_pay_reg    <= PAY_W'(rd_pay);
            res_act_reg    <= ACT_W'(used_reg);
            res_last_reg   <= ((emit_cnt_reg + 1'b1) == sel_cnt_reg);
        end
    end

    assign sts.list_more = (req_op_reg == OP_LIST) && (emit_cnt_reg != sel_cnt_reg);
    assign m_tdata = {7'b0, res_act_reg, res_pay_reg, res_port_reg, res_host_reg,
                      res_ch_reg, res_status_reg};
    assign m_tlast = res_last_reg;

endmodule

/* sv/cbt_checker.sv */
// Port-level checker for the channel binding table, bound to the top level.
`include "channel_binding_table_core_macros.svh"

module cbt_checker
    import cbt_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    // Hold a stalled result
    `CBT_ASSERT(a_res_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // Never take a request while a result is pending
    `CBT_ASSERT(a_one_at_a_time, s_tvalid |-> !(s_tready && m_tvalid))
    // Drop the result channel after reset
    `CBT_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid)
    // Report only known status codes
    `CBT_ASSERT(a_status_range, m_tvalid |-> m_tdata[2:0] <= STATUS_EMPTY)
    // Only a successful list result may be followed by more
    `CBT_ASSERT(a_more_is_ok, m_tvalid && !m_tlast |-> m_tdata[2:0] == STATUS_OK)

endmodule

bind channel_binding_table_core cbt_checker u_cbt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* tb/sv/tb_channel_binding_table_core.sv */
// Self-checking testbench for the channel binding table core.
`default_nettype none
module tb_channel_binding_table_core;
    import cbt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [HOST_W-1:0]  host;
        logic [PORT_W-1:0]  port;
        logic [CH_W-1:0]    ch;
        logic [PAY_W-1:0]   pay;
        logic [LIMIT_W-1:0] limit;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CH_W-1:0]     ch;
        logic [HOST_W-1:0]   host;
        logic [PORT_W-1:0]   port;
        logic [PAY_W-1:0]    pay;
        logic [ACT_W-1:0]    active;
        logic                last;
    } answer_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic m_tlast;

    channel_binding_table_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #4 aclk = ~aclk;

    // Shadow copy of the table
    logic                    tbl_valid [SLOT_COUNT];
    logic [HOST_W-1:0]       tbl_host  [SLOT_COUNT];
    logic [PORT_W-1:0]       tbl_port  [SLOT_COUNT];
    logic [CHANNEL_BITS-1:0] tbl_ch    [SLOT_COUNT];
    logic [PAY_W-1:0]        tbl_pay   [SLOT_COUNT];
    int                      tbl_used;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    int       error_count = 0;
    bit       stim_done = 1'b0;
    bit       quiet_phase = 1'b0;
    int       idle_cycles = 0;

    function automatic int slot_of_channel(int c);
        for (int i = 0; i < SLOT_COUNT; i++)
            if (tbl_valid[i] && tbl_ch[i] == c) return i;
        return -1;
    endfunction

    function automatic int slot_of_host(logic [HOST_W-1:0] h, logic [PORT_W-1:0] p);
        for (int i = 0; i < SLOT_COUNT; i++)
            if (tbl_valid[i] && tbl_host[i] == h && tbl_port[i] == p) return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < SLOT_COUNT; i++)
            if (!tbl_valid[i]) return i;
        return -1;
    endfunction

    function automatic void push_answer(logic [STATUS_W-1:0] st, int c, int s, bit l);
        answer_t a;
        a.status = st;
        a.ch     = CH_W'(c);
        a.host   = (s >= 0) ? tbl_host[s] : '0;
        a.port   = (s >= 0) ? tbl_port[s] : '0;
        a.pay    = (s >= 0) ? tbl_pay[s] : '0;
        a.active = ACT_W'(tbl_used);
        a.last   = l;
        expected_answers.push_back(a);
    endfunction

    function automatic void write_slot(int s, request_t r, int c);
        tbl_valid[s] = 1'b1;
        tbl_host[s]  = r.host;
        tbl_port[s]  = r.port;
        tbl_ch[s]    = CHANNEL_BITS'(c);
        tbl_pay[s]   = r.pay;
    endfunction

    // Predict the answers of one accepted request and update the shadow table
    function automatic void predict_table_op(request_t r);
        int  c, s, f, a, n, cap, j;
        bit  ch_ok;
        int  pick[16];
        c = $signed(r.ch);
        ch_ok = c >= 0 && c < CH_COUNT;
        case (r.op)
            OP_ADD: begin
                if (r.host == 0) begin
                    push_answer(STATUS_BAD, -1, -1, 1);
                    return;
                end
                s = slot_of_host(r.host, r.port);
                if (s >= 0) begin
                    push_answer(STATUS_OK, tbl_ch[s], -1, 1);
                    return;
                end
                f = free_slot();
                if (f < 0) begin
                    push_answer(STATUS_FULL, -1, -1, 1);
                    return;
                end
                if (ch_ok && slot_of_channel(c) < 0) a = c;
                else begin
                    a = 0;
                    while (a < CH_COUNT && slot_of_channel(a) >= 0) a++;
                    if (a >= CH_COUNT) begin
                        push_answer(STATUS_FULL, -1, -1, 1);
                        return;
                    end
                end
                write_slot(f, r, a);
                tbl_used++;
                push_answer(STATUS_OK, a, -1, 1);
            end
            OP_UPSERT: begin
                if (r.host == 0 || !ch_ok) begin
                    push_answer(STATUS_BAD, -1, -1, 1);
                    return;
                end
                s = slot_of_channel(c);
                if (s >= 0) write_slot(s, r, c);
                else begin
                    f = free_slot();
                    if (f < 0) begin
                        push_answer(STATUS_FULL, -1, -1, 1);
                        return;
                    end
                    write_slot(f, r, c);
                    tbl_used++;
                end
                push_answer(STATUS_OK, c, -1, 1);
            end
            OP_REMOVE: begin
                s = ch_ok ? slot_of_channel(c) : -1;
                if (s < 0) begin
                    push_answer(STATUS_NFOUND, -1, -1, 1);
                    return;
                end
                tbl_valid[s] = 1'b0;
                tbl_host[s] = '0; tbl_port[s] = '0; tbl_ch[s] = '0; tbl_pay[s] = '0;
                if (tbl_used > 0) tbl_used--;
                push_answer(STATUS_OK, c, -1, 1);
            end
            OP_GET: begin
                s = ch_ok ? slot_of_channel(c) : -1;
                if (s < 0) push_answer(STATUS_NFOUND, -1, -1, 1);
                else push_answer(STATUS_OK, tbl_ch[s], s, 1);
            end
            OP_FIND: begin
                s = slot_of_host(r.host, r.port);
                if (s < 0) push_answer(STATUS_NFOUND, -1, -1, 1);
                else push_answer(STATUS_OK, tbl_ch[s], -1, 1);
            end
            OP_LIST: begin
                n = 0;
                cap = r.limit;
                if (cap > LIST_MAX) cap = LIST_MAX;
                for (int i = 0; i < SLOT_COUNT && n < cap; i++) begin
                    if (tbl_valid[i]) begin
                        j = n;
                        while (j > 0 && tbl_ch[pick[j-1]] > tbl_ch[i]) begin
                            pick[j] = pick[j-1];
                            j--;
                        end
                        pick[j] = i;
                        n++;
                    end
                end
                if (n == 0) push_answer(STATUS_EMPTY, -1, -1, 1);
                else for (int i = 0; i < n; i++)
                    push_answer(STATUS_OK, tbl_ch[pick[i]], pick[i], i == n - 1);
            end
            default: push_answer(STATUS_BAD, -1, -1, 1);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [HOST_W-1:0] got, logic [HOST_W-1:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver: present the queued requests, idling at random, and stall answers at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() > 0 &&
                    (quiet_phase || $urandom_range(99) >= 24)) begin
                    request_t r;
                    r = pending_requests.pop_front();
                    s_tdata <= {7'd0, r.limit, r.pay, r.ch, r.port, r.host, r.op};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= quiet_phase || ($urandom_range(99) >= 24);
        end
    end

    // Monitor: predict on accepted requests, compare accepted answers
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_table_op(request_t'({s_tdata[2:0], s_tdata[66:3], s_tdata[82:67],
                    s_tdata[91:83], s_tdata[123:92], s_tdata[128:124]}));
            end
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected answer", m_tdata[63:0], '0);
                end else begin
                    answer_t e;
                    e = expected_answers.pop_front();
                    if (m_tdata[2:0] !== e.status) report_mismatch("status", m_tdata[2:0], e.status);
                    if (m_tdata[11:3] !== e.ch) report_mismatch("channel", m_tdata[11:3], e.ch);
                    if (m_tdata[75:12] !== e.host) report_mismatch("host", m_tdata[75:12], e.host);
                    if (m_tdata[91:76] !== e.port) report_mismatch("port", m_tdata[91:76], e.port);
                    if (m_tdata[123:92] !== e.pay) report_mismatch("payload", m_tdata[123:92], e.pay);
                    if (m_tdata[128:124] !== e.active)
                        report_mismatch("active count", m_tdata[128:124], e.active);
                    if (m_tlast !== e.last) report_mismatch("last", m_tlast, e.last);
                end
            end
            // Watchdog on handshake progress
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d answers pending", expected_answers.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic request_t make_request(logic [OP_W-1:0] op, logic [HOST_W-1:0] h,
                                              logic [PORT_W-1:0] p, int c,
                                              logic [PAY_W-1:0] pl, int lim);
        request_t r;
        r.op = op; r.host = h; r.port = p; r.ch = CH_W'(c); r.pay = pl;
        r.limit = LIMIT_W'(lim);
        return r;
    endfunction

    function automatic logic [HOST_W-1:0] rand_host(bit pool);
        if (pool) return HOST_W'($urandom_range(1, 6));
        return {$urandom, $urandom};
    endfunction

    // Channel mostly from a small pool so lookups hit often
    function automatic int rand_channel();
        case ($urandom_range(9))
            0: return -int'($urandom_range(1, 256));
            1: return $urandom_range(255);
            default: return $urandom_range(20);
        endcase
    endfunction

    initial begin
        request_t r;
        int op;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tbl_valid[i] = 0; tbl_host[i] = '0; tbl_port[i] = '0; tbl_ch[i] = '0;
            tbl_pay[i] = '0;
        end
        tbl_used = 0;

        // Directed: empty list, misses, bad parameters, extremes, full table
        pending_requests.push_back(make_request(OP_LIST, 1, 0, 0, 0, 16));
        pending_requests.push_back(make_request(OP_GET, 1, 0, 0, 0, 1));
        pending_requests.push_back(make_request(OP_REMOVE, 1, 0, -1, 0, 1));
        pending_requests.push_back(make_request(OP_FIND, 5, 5, 0, 0, 1));
        pending_requests.push_back(make_request(OP_ADD, 0, 0, 3, 0, 0));
        pending_requests.push_back(make_request(OP_UPSERT, 7, 1, -256, 0, 0));
        pending_requests.push_back(make_request(OP_UPSERT, 0, 1, 4, 0, 0));
        pending_requests.push_back(make_request(3'd6, 7, 1, 4, 0, 0));
        pending_requests.push_back(make_request(3'd7, 7, 1, 4, 0, 0));
        pending_requests.push_back(make_request(OP_ADD, '1, '1, 255, '1, 31));
        pending_requests.push_back(make_request(OP_ADD, '1, '1, 10, 0, 0));
        pending_requests.push_back(make_request(OP_ADD, 2, 0, -1, 32'h5a5a, 0));
        pending_requests.push_back(make_request(OP_UPSERT, 3, 9, 0, 32'h1234, 0));
        pending_requests.push_back(make_request(OP_UPSERT, 2, 0, 7, 1, 0));
        pending_requests.push_back(make_request(OP_ADD, 2, 0, 9, 0, 0));
        pending_requests.push_back(make_request(OP_FIND, 2, 0, 0, 0, 0));
        for (int i = 0; i < 12; i++)
            pending_requests.push_back(make_request(OP_ADD, 100 + i, i, -1, i, 0));
        pending_requests.push_back(make_request(OP_ADD, 200, 0, 3, 0, 0));
        pending_requests.push_back(make_request(OP_UPSERT, 201, 0, 200, 0, 0));
        pending_requests.push_back(make_request(OP_LIST, 0, 0, 0, 0, 31));
        pending_requests.push_back(make_request(OP_LIST, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_GET, 0, 0, 255, 0, 0));
        pending_requests.push_back(make_request(OP_REMOVE, 0, 0, 255, 0, 0));

        // Random: mixed operations on a small key and channel pool
        for (int i = 0; i < 320; i++) begin
            op = $urandom_range(99);
            r.host  = rand_host($urandom_range(3) != 0);
            r.port  = ($urandom_range(3) != 0) ? PORT_W'($urandom_range(2)) : PORT_W'($urandom);
            r.ch    = CH_W'(rand_channel());
            r.pay   = $urandom;
            r.limit = ($urandom_range(3) == 0) ? LIMIT_W'($urandom) : LIMIT_W'($urandom_range(4));
            if ($urandom_range(19) == 0) r.host = '0;
            if (op < 22) r.op = OP_ADD;
            else if (op < 40) r.op = OP_UPSERT;
            else if (op < 62) r.op = OP_REMOVE;
            else if (op < 76) r.op = OP_GET;
            else if (op < 88) r.op = OP_FIND;
            else if (op < 97) r.op = OP_LIST;
            else r.op = OP_W'($urandom_range(6, 7));
            pending_requests.push_back(r);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        // Long stretch with no idling in the middle of the run
        wait (pending_requests.size() < 200);
        quiet_phase = 1'b1;
        wait (pending_requests.size() < 120);
        quiet_phase = 1'b0;
        // Wait until the last request is accepted and all its answers are taken
        wait (pending_requests.size() == 0 && !s_tvalid);
        wait (expected_answers.size() == 0);
        repeat (40) @(posedge aclk);
        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
